// ===== rtl/button_and_status_input_qualifier_unit_defines.svh =====
// Assertion macros used by the checker file of the input qualifier.
// Needs nothing else; include by bare file name.
`ifndef BUTTON_AND_STATUS_INPUT_QUALIFIER_UNIT_DEFINES_SVH
`define BUTTON_AND_STATUS_INPUT_QUALIFIER_UNIT_DEFINES_SVH

// Check a property on every edge outside reset.
`define BSIQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bsiq assertion failed");

// Check a property on every edge, reset included.
`define BSIQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bsiq assertion failed");

`endif

// ===== rtl/bsiq_pkg.sv =====
// Types, constants and helpers of the button and status input qualifier.
// No dependencies.
package bsiq_pkg;

  localparam int unsigned PeriodW = 8;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned ShortW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LinesW  = 4;

  // bit positions in the sample and qualified level words
  localparam int unsigned BitBtn  = 0;
  localparam int unsigned BitChgA = 1;
  localparam int unsigned BitChgB = 2;
  localparam int unsigned BitCard = 3;

  // charge state code bits
  localparam int unsigned ChgOneBit = 0;
  localparam int unsigned ChgTwoBit = 1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSamplePeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPress    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgShortPress   = 2'd2;

  // reset values
  localparam logic [PeriodW-1:0] SamplePeriodRst = 8'd10;
  localparam logic [TimerW-1:0]  LongPressRst    = 16'd500;
  localparam logic [ShortW-1:0]  ShortPressRst   = 8'd10;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic short_passed;
  } press_status_t;

  function automatic logic [1:0] charge_code(input logic [LinesW-1:0] levels);
    logic [1:0] c;
    c = 2'b00;
    c[ChgOneBit] = levels[BitChgA];
    c[ChgTwoBit] = levels[BitChgB];
    return c;
  endfunction

endpackage

// ===== rtl/button_and_status_input_qualifier_unit.sv =====
// Top level of the button and status input qualifier.
// Depends on bsiq_pkg and bsiq_press_timer.
//
//   channel | handshake                 | carries
//   --------+---------------------------+--------------------------------------
//   in      | in_valid_i / in_stall_o   | one tick: four pin levels, ack
//   out     | out_valid_o / out_stall_i | one status word per tick
//   cfg     | cfg_valid_i / cfg_ready_o | register index and data
//
// One word per clock unless out_stall_i stalls; the registered result shows in the next cycle.
// Sampling, qualification and the press timer all update together when a tick is taken.
// Async active-low reset loads the register reset values and empties output.
// in_stall_o rises only while a result is held and out_stall_i is high.
// cfg_ready_o is always high.
module button_and_status_input_qualifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            button_pin_n_i,
  input  logic                            charge_stat_a_n_i,
  input  logic                            charge_stat_b_n_i,
  input  logic                            card_sense_n_i,
  input  logic                            long_press_ack_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            sampled_o,
  output logic                            button_held_o,
  output logic                            short_press_o,
  output logic                            long_press_o,
  output logic                            short_period_passed_o,
  output logic [1:0]                      charge_state_o,
  output logic                            card_present_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsiq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bsiq_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [bsiq_pkg::PeriodW-1:0] period_q;
  logic [bsiq_pkg::TimerW-1:0]  long_thr_q;
  logic [bsiq_pkg::ShortW-1:0]  short_thr_q;

  logic [bsiq_pkg::PeriodW-1:0] tick_q, tick_d, tick_dec;
  logic [bsiq_pkg::TimerW-1:0]  timer_q, timer_d;
  logic                         flag_q, flag_d;
  logic [bsiq_pkg::LinesW-1:0]  prev_q, prev_d;
  logic [bsiq_pkg::LinesW-1:0]  qual_q, qual_d;
  logic [bsiq_pkg::LinesW-1:0]  cur;

  logic                         out_valid_q, out_valid_d;
  logic                         sampled_q, held_q, short_q, long_q, passed_q, card_q;
  logic [1:0]                   charge_q;

  logic                         in_acc;
  logic                         sample;
  logic                         released;
  bsiq_pkg::press_status_t      status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  assign tick_dec = tick_q - 8'd1;
  assign sample   = (tick_dec == '0);
  assign tick_d   = sample ? period_q : tick_dec;

  always_comb begin
    cur = '0;
    cur[bsiq_pkg::BitBtn]  = !button_pin_n_i;
    cur[bsiq_pkg::BitChgA] = !charge_stat_a_n_i;
    cur[bsiq_pkg::BitChgB] = !charge_stat_b_n_i;
    cur[bsiq_pkg::BitCard] = !card_sense_n_i;
  end

  assign released = sample && qual_q[bsiq_pkg::BitBtn] && prev_q[bsiq_pkg::BitBtn]
                    && !cur[bsiq_pkg::BitBtn];
  assign qual_d   = sample ? (prev_q & cur) : qual_q;
  assign prev_d   = sample ? cur : prev_q;

  bsiq_press_timer u_press (
    .sample_i    (sample),
    .held_i      (qual_d[bsiq_pkg::BitBtn]),
    .released_i  (released),
    .ack_i       (long_press_ack_i),
    .long_thr_i  (long_thr_q),
    .short_thr_i (short_thr_q),
    .timer_i     (timer_q),
    .flag_i      (flag_q),
    .timer_o     (timer_d),
    .flag_o      (flag_d),
    .status_o    (status)
  );

  assign out_valid_d = in_acc ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= bsiq_pkg::SamplePeriodRst;
      long_thr_q  <= bsiq_pkg::LongPressRst;
      short_thr_q <= bsiq_pkg::ShortPressRst;
      tick_q      <= bsiq_pkg::SamplePeriodRst;
      timer_q     <= '0;
      flag_q      <= 1'b0;
      prev_q      <= '0;
      qual_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bsiq_pkg::CfgSamplePeriod: period_q    <= cfg_data_i[bsiq_pkg::PeriodW-1:0];
          bsiq_pkg::CfgLongPress:    long_thr_q  <= cfg_data_i[bsiq_pkg::TimerW-1:0];
          bsiq_pkg::CfgShortPress:   short_thr_q <= cfg_data_i[bsiq_pkg::ShortW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        tick_q  <= tick_d;
        timer_q <= timer_d;
        flag_q  <= flag_d;
        prev_q  <= prev_d;
        qual_q  <= qual_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sampled_q <= sample;
      held_q    <= qual_d[bsiq_pkg::BitBtn];
      short_q   <= status.short_press;
      long_q    <= status.long_press;
      passed_q  <= status.short_passed;
      charge_q  <= bsiq_pkg::charge_code(qual_d);
      card_q    <= qual_d[bsiq_pkg::BitCard];
    end
  end

  assign out_valid_o           = out_valid_q;
  assign sampled_o             = sampled_q;
  assign button_held_o         = held_q;
  assign short_press_o         = short_q;
  assign long_press_o          = long_q;
  assign short_period_passed_o = passed_q;
  assign charge_state_o        = charge_q;
  assign card_present_o        = card_q;

endmodule

// ===== rtl/bsiq_press_timer.sv =====
// Press timer next-state logic: hold count, long-press flag, short pulse.
// Depends on bsiq_pkg.
module bsiq_press_timer (
  input  logic                          sample_i,
  input  logic                          held_i,
  input  logic                          released_i,
  input  logic                          ack_i,
  input  logic [bsiq_pkg::TimerW-1:0]   long_thr_i,
  input  logic [bsiq_pkg::ShortW-1:0]   short_thr_i,
  input  logic [bsiq_pkg::TimerW-1:0]   timer_i,
  input  logic                          flag_i,
  output logic [bsiq_pkg::TimerW-1:0]   timer_o,
  output logic                          flag_o,
  output bsiq_pkg::press_status_t       status_o
);

  logic [bsiq_pkg::TimerW-1:0] timer_s;
  logic [bsiq_pkg::TimerW-1:0] timer_inc;
  logic [bsiq_pkg::TimerW-1:0] short_ext;
  logic                        flag_s;
  logic                        pulse;

  assign timer_inc = timer_i + 16'd1;
  assign short_ext = {{(bsiq_pkg::TimerW-bsiq_pkg::ShortW){1'b0}}, short_thr_i};

  always_comb begin
    timer_s = timer_i;
    flag_s  = flag_i;
    pulse   = 1'b0;
    if (sample_i) begin
      if (held_i) begin
        if (timer_i < long_thr_i) begin
          timer_s = timer_inc;
          if (timer_inc == long_thr_i) begin
            flag_s = 1'b1;
          end
        end
      end else begin
        pulse   = released_i && (timer_i >= short_ext) && (timer_i < long_thr_i);
        timer_s = '0;
      end
    end
  end

  assign status_o.short_press  = pulse;
  assign status_o.long_press   = flag_s;
  assign status_o.short_passed = (timer_s > short_ext);

  // acknowledge acts after the tick and only on a set flag
  assign flag_o  = (ack_i && flag_s) ? 1'b0 : flag_s;
  assign timer_o = (ack_i && flag_s) ? '0 : timer_s;

endmodule

// ===== rtl/bsiq_checker.sv =====
// Port-level checks of the input qualifier, bound to the top level.
// Depends on the assertion macro header.
`include "button_and_status_input_qualifier_unit_defines.svh"

module bsiq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       sampled_o,
  input logic       button_held_o,
  input logic       short_press_o,
  input logic       long_press_o,
  input logic       short_period_passed_o,
  input logic [1:0] charge_state_o,
  input logic       card_present_o,
  input logic       cfg_ready_o
);

  logic       out_busy;
  logic       short_seen;
  logic [7:0] out_word;

  assign out_busy   = out_valid_o && out_stall_i;
  assign short_seen = out_valid_o && short_press_o;
  assign out_word   = {sampled_o, button_held_o, short_press_o, long_press_o,
                       short_period_passed_o, charge_state_o, card_present_o};

  `BSIQ_ASSERT(a_out_hold, clk_i, rst_ni, out_busy |=> out_valid_o && $stable(out_word))
  `BSIQ_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> out_busy)
  `BSIQ_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o |=> in_valid_i)
  `BSIQ_ASSERT(a_short_needs_sample, clk_i, rst_ni, short_seen |-> sampled_o && !button_held_o)
  `BSIQ_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o)

endmodule

bind button_and_status_input_qualifier_unit bsiq_checker u_bsiq_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .sampled_o             (sampled_o),
  .button_held_o         (button_held_o),
  .short_press_o         (short_press_o),
  .long_press_o          (long_press_o),
  .short_period_passed_o (short_period_passed_o),
  .charge_state_o        (charge_state_o),
  .card_present_o        (card_present_o),
  .cfg_ready_o           (cfg_ready_o)
);
